### design/rmmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmmm_pkg
// Shared field widths and transaction payload types of the running mean,
// minimum and maximum block.
// ----------------------------------------------------------------------------
package rmmm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                          command;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean_value;
        logic signed [SAMPLE_BITS-1:0] min_value;
        logic signed [SAMPLE_BITS-1:0] max_value;
        logic        [COUNT_BITS-1:0]  count_value;
        logic                          accepted;
    } t_out_item;

endpackage

### design/rmmm_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmmm_serial_div
// Restoring unsigned divider, one quotient bit per cycle. The divisor must be
// nonzero and held stable while the division runs.
// ----------------------------------------------------------------------------
module rmmm_serial_div #(
    parameter int NUM_BITS = 33,
    parameter int DEN_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_dividend,
    input  logic [DEN_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [DEN_BITS-1:0] r_rem,   n_rem;
    logic [NUM_BITS-1:0] r_shift, n_shift;
    logic [CNT_BITS-1:0] r_cnt,   n_cnt;
    logic                r_busy,  n_busy;
    logic                r_done,  n_done;

    logic [DEN_BITS:0]   w_part;
    logic [DEN_BITS:0]   w_trial;

    always_comb begin
        w_part  = {r_rem, r_shift[NUM_BITS-1]};
        w_trial = w_part - {1'b0, i_divisor};
        n_rem   = r_rem;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem   = '0;
            n_shift = i_dividend;
            n_cnt   = CNT_BITS'(NUM_BITS - 1);
            n_busy  = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[DEN_BITS]) begin
                n_rem   = w_trial[DEN_BITS-1:0];
                n_shift = {r_shift[NUM_BITS-2:0], 1'b1};
            end else begin
                n_rem   = w_part[DEN_BITS-1:0];
                n_shift = {r_shift[NUM_BITS-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_shift <= n_shift;
        r_cnt   <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_shift;

endmodule

### design/running_mean_min_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_min_max
// Cumulative mean, minimum, maximum and saturating count of sensor samples.
// A sample passes the states DIFF, START, DIV (the bit-serial divider) and
// FIX before DONE writes the result; clear commands and items taken while
// averaging is off go straight to DONE. One transaction at a time: the next
// is taken once the result is in the output register. Reset zeroes the
// statistics and enables averaging.
// ----------------------------------------------------------------------------
module running_mean_min_max
    import rmmm_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int MEAN_BITS = SAMPLE_BITS + FRACTION_BITS;
    localparam int DIFF_BITS = MEAN_BITS + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIFF  = 6'b000010,
        S_START = 6'b000100,
        S_DIV   = 6'b001000,
        S_FIX   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_enable;
    logic signed [MEAN_BITS-1:0]    r_mean, n_mean;
    logic signed [SAMPLE_BITS-1:0]  r_min,  n_min;
    logic signed [SAMPLE_BITS-1:0]  r_max,  n_max;
    logic        [COUNT_BITS-1:0]   r_count, n_count;
    logic signed [SAMPLE_BITS-1:0]  r_sample, n_sample;
    logic                           r_acc,  n_acc;
    logic signed [DIFF_BITS-1:0]    r_diff, n_diff;
    logic                           r_out_valid, n_out_valid;
    t_out_item                      r_out, n_out;

    logic signed [DIFF_BITS-1:0]    w_scaled;
    logic        [DIFF_BITS-1:0]    w_mag;
    logic        [DIFF_BITS-1:0]    w_quot;
    logic        [DIFF_BITS-1:0]    w_sum;
    logic                           w_div_start;
    logic                           w_div_done;
    logic                           w_accept;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_scaled    = $signed({{(DIFF_BITS-SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample})
                         <<< FRACTION_BITS;
    assign w_mag       = r_diff[DIFF_BITS-1] ? (~r_diff + 1'b1) : r_diff;
    assign w_div_start = (r_state == S_START);
    // signed quotient folded into the add through the carry in
    assign w_sum       = {r_mean[MEAN_BITS-1], r_mean}
                         + (r_diff[DIFF_BITS-1] ? ~w_quot : w_quot)
                         + {{(DIFF_BITS-1){1'b0}}, r_diff[DIFF_BITS-1]};

    rmmm_serial_div #(
        .NUM_BITS (DIFF_BITS),
        .DEN_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_mean      = r_mean;
        n_min       = r_min;
        n_max       = r_max;
        n_count     = r_count;
        n_sample    = r_sample;
        n_acc       = r_acc;
        n_diff      = r_diff;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sample = i_in_data.sample;
                    n_acc    = r_enable;
                    n_state  = S_DONE;
                    if (r_enable) begin
                        if (i_in_data.command == CMD_CLEAR) begin
                            n_mean  = '0;
                            n_min   = '0;
                            n_max   = '0;
                            n_count = '0;
                        end else begin
                            if (r_count != '1) begin
                                n_count = r_count + 1'b1;
                            end
                            if (r_count == '0) begin
                                n_min = i_in_data.sample;
                                n_max = i_in_data.sample;
                            end else begin
                                if (i_in_data.sample < r_min) begin
                                    n_min = i_in_data.sample;
                                end
                                if (i_in_data.sample > r_max) begin
                                    n_max = i_in_data.sample;
                                end
                            end
                            n_state = S_DIFF;
                        end
                    end
                end
            end
            S_DIFF: begin
                n_diff  = w_scaled - {r_mean[MEAN_BITS-1], r_mean};
                n_state = S_START;
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_mean  = w_sum[MEAN_BITS-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.mean_value  = r_mean[MEAN_BITS-1:FRACTION_BITS];
                    n_out.min_value   = r_min;
                    n_out.max_value   = r_max;
                    n_out.count_value = r_count;
                    n_out.accepted    = r_acc;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_acc    <= n_acc;
        r_diff   <= n_diff;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b1;
            r_mean      <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mean      <= n_mean;
            r_min       <= n_min;
            r_max       <= n_max;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### tb/running_mean_min_max_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_min_max_tb
// Self-checking bench for the running mean, minimum and maximum block. The
// stimulus is a directed run, a run of samples without clears, and
// random samples and clears under four idle and stall patterns, with the
// averaging enable toggled between runs. A scoreboard tracks the statistics
// on each input transaction and checks every result field in order.
// ----------------------------------------------------------------------------
module running_mean_min_max_tb;
    import rmmm_pkg::*;

    localparam int          FRAC_BITS = 16;
    localparam int unsigned COUNT_TOP = (1 << COUNT_BITS) - 1;
    localparam logic        AVG_OFF   = 1'b0;
    localparam logic        AVG_ON    = 1'b1;

    class stat_board;
        bit                            enabled;
        longint                        mean_fx;
        logic signed [SAMPLE_BITS-1:0] low_s;
        logic signed [SAMPLE_BITS-1:0] high_s;
        int unsigned                   n_samples;
        t_out_item                     expected_q[$];
        int                            errors;

        function new();
            enabled = 1'b1;
            errors  = 0;
            wipe();
        endfunction

        function void wipe();
            mean_fx   = 0;
            low_s     = '0;
            high_s    = '0;
            n_samples = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            longint    scaled;
            if (enabled) begin
                if (it.command == CMD_CLEAR) begin
                    wipe();
                end else begin
                    scaled = longint'(it.sample) <<< FRAC_BITS;
                    if (n_samples < COUNT_TOP) begin
                        n_samples++;
                    end
                    if (n_samples == 1) begin
                        mean_fx = scaled;
                        low_s   = it.sample;
                        high_s  = it.sample;
                    end else begin
                        // long division truncates toward zero
                        mean_fx += (scaled - mean_fx) / longint'(n_samples);
                        if (it.sample > high_s) begin
                            high_s = it.sample;
                        end
                        if (it.sample < low_s) begin
                            low_s = it.sample;
                        end
                    end
                end
            end
            r.mean_value  = SAMPLE_BITS'(mean_fx >>> FRAC_BITS);
            r.min_value   = low_s;
            r.max_value   = high_s;
            r.count_value = COUNT_BITS'(n_samples);
            r.accepted    = enabled;
            expected_q.push_back(r);
        endfunction

        function void report(string field, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result transaction, actual %p", $time, got);
            end else begin
                want = expected_q.pop_front();
                report("mean_value", want.mean_value, got.mean_value);
                report("min_value", want.min_value, got.min_value);
                report("max_value", want.max_value, got.max_value);
                report("count_value", want.count_value, got.count_value);
                report("accepted", want.accepted, got.accepted);
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    int        idle_pct  = 0;
    int        stall_pct = 0;
    int        hold_asks = 0;
    int        hold_seen = 0;

    stat_board sb = new();

    running_mean_min_max #(
        .FRACTION_BITS(FRAC_BITS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        forever begin
            #10 clk = ~clk;
        end
    end

    initial begin
        #300_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                sb.note_input(in_data);
            end
            if (o_out_valid && out_ready) begin
                sb.check_result(o_out_data);
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send(input t_in_item it);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 50)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!o_in_ready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_cmd(input logic cmd, input logic signed [SAMPLE_BITS-1:0] value);
        t_in_item it;
        it.command = cmd;
        it.sample  = value;
        send(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
    endtask

    task automatic set_averaging(input logic on);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.enabled = on;
    endtask

    task automatic send_random(input int n, input int clear_pct);
        t_in_item it;
        repeat (n) begin
            it.command = ($urandom_range(99) < clear_pct) ? CMD_CLEAR : CMD_ADD;
            case ($urandom_range(9))
                0:       it.sample = 16'sh7fff;
                1:       it.sample = 16'sh8000;
                2, 3:    it.sample = SAMPLE_BITS'($urandom_range(200) - 100);
                4:       it.sample = SAMPLE_BITS'($urandom_range(8000) + 20000);
                default: it.sample = SAMPLE_BITS'($urandom());
            endcase
            send(it);
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_averaging(AVG_ON);

        // directed: extremes, clears, negative first sample
        send_cmd(CMD_CLEAR, 16'sh7fff);
        send_cmd(CMD_ADD, 16'sh7fff);
        send_cmd(CMD_ADD, 16'sh8000);
        send_cmd(CMD_ADD, 16'sh0000);
        send_cmd(CMD_ADD, -16'sd1);
        send_cmd(CMD_ADD, 16'sd1);
        send_cmd(CMD_ADD, 16'sh5555);
        send_cmd(CMD_ADD, 16'shaaaa);
        send_cmd(CMD_ADD, 16'sh8000);
        send_cmd(CMD_ADD, 16'sh8000);
        send_cmd(CMD_CLEAR, 16'sh8000);
        send_cmd(CMD_ADD, -16'sd1);
        send_cmd(CMD_ADD, -16'sd2);
        send_cmd(CMD_ADD, 16'sh7fff);
        send_cmd(CMD_ADD, -16'sd3);

        // averaging off: items leave the statistics alone
        set_averaging(AVG_OFF);
        send_cmd(CMD_ADD, 16'sd100);
        send_cmd(CMD_CLEAR, 16'sd0);
        send_cmd(CMD_ADD, 16'sh8000);
        set_averaging(AVG_ON);
        send_cmd(CMD_ADD, 16'sd7);

        // a longer run of samples without clears
        send_cmd(CMD_CLEAR, 16'sd0);
        send_random(40, 0);
        send_cmd(CMD_ADD, 16'sh7fff);
        send_cmd(CMD_ADD, 16'sh8000);
        send_cmd(CMD_CLEAR, 16'sd0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            set_averaging(AVG_ON);
            if (ph == 0) begin
                // long receiver hold-off while items keep coming
                hold_asks <= hold_asks + 1;
            end
            send_random(400, 3);
            set_averaging(AVG_OFF);
            send_random(30, 20);
        end
        set_averaging(AVG_ON);
        send_random(20, 10);

        drain();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
